FILE: rtl/assert_macros.svh
// Assertion macros shared by the grading coefficient RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while in reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/pgc_pkg.sv
// Package: types and constants of the PML grading coefficient block.
`timescale 1ns / 1ps

package pgc_pkg;

    // register widths and limits
    localparam int START_BITS = 12;
    localparam int WIDTH_BITS = 11;
    localparam int AXIS_BITS  = 13;
    localparam int COORD_BITS = 12;
    localparam int MAX_LAYER  = 1024;
    localparam int MAX_EXTENT = 4096;

    // output format
    localparam int OUT_BITS = 19;
    localparam int NUM_COEF = 5;

    // divider operand width: 4*W^3 + (2W-1)^3 for W = MAX_LAYER
    localparam int DW = 34;

    // register indexes
    localparam logic [1:0] REG_START      = 2'd0;
    localparam logic [1:0] REG_WIDTH_LOW  = 2'd1;
    localparam logic [1:0] REG_WIDTH_HIGH = 2'd2;
    localparam logic [1:0] REG_AXIS_SIZE  = 2'd3;

    // clamped configuration seen by the datapath
    typedef struct packed {
        logic [START_BITS-1:0] start;
        logic [WIDTH_BITS-1:0] wl;
        logic [WIDTH_BITS-1:0] wh;
        logic [AXIS_BITS-1:0]  n;
    } t_cfg;

    // divider operands for one cell
    typedef struct packed {
        logic [NUM_COEF-1:0][DW-1:0] num;
        logic [NUM_COEF-1:0][DW-1:0] den;
        logic                        neg1;
        logic                        neg4;
        logic                        hit;
    } t_ops;

endpackage

FILE: rtl/pgc_cfg.sv
// Configuration registers with APB-style access and clamping.
`timescale 1ns / 1ps

module pgc_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output pgc_pkg::t_cfg o_cfg
);
    import pgc_pkg::*;
    `include "assert_macros.svh"

    logic [START_BITS-1:0] r_start;
    logic [WIDTH_BITS-1:0] r_wl;
    logic [WIDTH_BITS-1:0] r_wh;
    logic [AXIS_BITS-1:0]  r_n;
    logic                  wr;

    assign wr = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_wl    <= '0;
            r_wh    <= '0;
            r_n     <= AXIS_BITS'(MAX_EXTENT);
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_START:      r_start <= pwdata[START_BITS-1:0];
                REG_WIDTH_LOW:  r_wl    <= pwdata[WIDTH_BITS-1:0];
                REG_WIDTH_HIGH: r_wh    <= pwdata[WIDTH_BITS-1:0];
                REG_AXIS_SIZE:  r_n     <= pwdata[AXIS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[3:2])
            REG_START:      prdata = 32'(r_start);
            REG_WIDTH_LOW:  prdata = 32'(r_wl);
            REG_WIDTH_HIGH: prdata = 32'(r_wh);
            REG_AXIS_SIZE:  prdata = 32'(r_n);
            default:        prdata = '0;
        endcase
    end

    // clamp widths and axis size
    always_comb begin
        o_cfg.start = r_start;
        o_cfg.wl = (r_wl > WIDTH_BITS'(MAX_LAYER)) ? WIDTH_BITS'(MAX_LAYER) : r_wl;
        o_cfg.wh = (r_wh > WIDTH_BITS'(MAX_LAYER)) ? WIDTH_BITS'(MAX_LAYER) : r_wh;
        o_cfg.n  = (r_n > AXIS_BITS'(MAX_EXTENT)) ? AXIS_BITS'(MAX_EXTENT) : r_n;
    end

    `ASSERT_CLK(a_start_wr, i_clk, i_rst_n, (wr && paddr[3:2] == REG_START) |=> (r_start == $past(pwdata[START_BITS-1:0])), "start margin write lost")
    `ASSERT_IMPL(a_clamp, i_clk, i_rst_n, 1'b1, (o_cfg.wl <= WIDTH_BITS'(MAX_LAYER)) && (o_cfg.wh <= WIDTH_BITS'(MAX_LAYER)), "layer width not clamped")

endmodule

FILE: rtl/pgc_front.sv
// Front pipeline: layer decode, cubes and divider operand forming.
`timescale 1ns / 1ps

module pgc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [pgc_pkg::COORD_BITS-1:0] i_coord,
    input  pgc_pkg::t_cfg               i_cfg,
    output logic                        o_valid,
    output pgc_pkg::t_ops               o_ops
);
    import pgc_pkg::*;

    // stage A: layer decode
    logic signed [14:0]    c_s, s_s, wl_s, wh_s, n_s, t_lo, t_hi_a, t_hi_b, d_lo, d_hi;
    logic                  lo_hit, hi_hit;
    logic                  r_va, r_hit_a;
    logic [WIDTH_BITS-1:0] r_d_a, r_w_a, n_d_a, n_w_a;

    assign c_s  = 15'(i_coord);
    assign s_s  = 15'(i_cfg.start);
    assign wl_s = 15'(i_cfg.wl);
    assign wh_s = 15'(i_cfg.wh);
    assign n_s  = 15'(i_cfg.n);
    assign t_lo   = s_s + wl_s;
    assign t_hi_a = n_s - s_s - wh_s;
    assign t_hi_b = n_s - s_s;
    assign lo_hit = (c_s >= s_s) && (c_s < t_lo);
    assign hi_hit = (c_s > t_hi_a) && (c_s <= t_hi_b);
    assign d_lo = t_lo - c_s;
    assign d_hi = c_s - t_hi_a;

    always_comb begin
        if (hi_hit) begin
            n_d_a = d_hi[WIDTH_BITS-1:0];
            n_w_a = i_cfg.wh;
        end else begin
            n_d_a = d_lo[WIDTH_BITS-1:0];
            n_w_a = i_cfg.wl;
        end
    end

    // stage B: squares
    logic                  r_vb, r_hit_b;
    logic [WIDTH_BITS-1:0] r_d_b, r_w_b;
    logic [11:0]           r_h_b, n_h_b;
    logic [21:0]           r_dd_b, r_ww_b, r_hh_b;

    assign n_h_b = {r_d_a, 1'b0} - 12'd1;

    // stage C: cubes
    logic        r_vc, r_hit_c;
    logic [30:0] r_d3_c, r_w3_c;
    logic [32:0] r_h3_c;
    logic [32:0] p_d3, p_w3;
    logic [33:0] p_h3;

    assign p_d3 = 33'(r_dd_b) * 33'(r_d_b);
    assign p_w3 = 33'(r_ww_b) * 33'(r_w_b);
    assign p_h3 = 34'(r_hh_b) * 34'(r_h_b);

    // stage D: operands
    logic [DW-1:0] d3x2, w3, w3x4, h3;
    t_ops          n_ops, r_ops;
    logic          r_vd;

    assign d3x2 = DW'({r_d3_c, 1'b0});
    assign w3   = DW'(r_w3_c);
    assign w3x4 = DW'({r_w3_c, 2'b00});
    assign h3   = DW'(r_h3_c);

    always_comb begin
        n_ops.hit    = r_hit_c;
        n_ops.neg1   = w3 < d3x2;
        n_ops.neg4   = w3x4 < h3;
        n_ops.num[0] = w3;
        n_ops.den[0] = w3 + d3x2;
        n_ops.num[1] = n_ops.neg1 ? (d3x2 - w3) : (w3 - d3x2);
        n_ops.den[1] = w3 + d3x2;
        n_ops.num[2] = h3;
        n_ops.den[2] = w3x4;
        n_ops.num[3] = w3x4;
        n_ops.den[3] = w3x4 + h3;
        n_ops.num[4] = n_ops.neg4 ? (h3 - w3x4) : (w3x4 - h3);
        n_ops.den[4] = w3x4 + h3;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit_a <= lo_hit || hi_hit;
            r_d_a   <= n_d_a;
            r_w_a   <= n_w_a;
            r_hit_b <= r_hit_a;
            r_d_b   <= r_d_a;
            r_w_b   <= r_w_a;
            r_h_b   <= n_h_b;
            r_dd_b  <= 22'(r_d_a) * 22'(r_d_a);
            r_ww_b  <= 22'(r_w_a) * 22'(r_w_a);
            r_hh_b  <= 22'(n_h_b) * 22'(n_h_b);
            r_hit_c <= r_hit_b;
            r_d3_c  <= p_d3[30:0];
            r_w3_c  <= p_w3[30:0];
            r_h3_c  <= p_h3[32:0];
            r_ops   <= n_ops;
        end
    end

    assign o_valid = r_vd;
    assign o_ops   = r_ops;

endmodule

FILE: rtl/pgc_div.sv
// Pipelined restoring divider, one quotient bit per stage (num < 2*den).
`timescale 1ns / 1ps

module pgc_div #(
    parameter int QB = 18
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [pgc_pkg::DW-1:0]   i_num,
    input  logic [pgc_pkg::DW-1:0]   i_den,
    output logic [QB-1:0]            o_quot
);
    import pgc_pkg::*;

    logic [DW:0]   r_rem [QB];
    logic [DW-1:0] r_den [QB];
    logic [QB-1:0] r_q   [QB];
    logic [DW:0]   n_rem [QB];
    logic [QB-1:0] n_q   [QB];
    logic [DW:0]   s_rem [QB];
    logic [DW-1:0] s_den [QB];
    logic [QB-1:0] s_q   [QB];

    // stage inputs: operands at stage 0, previous stage registers after that
    assign s_rem[0] = {1'b0, i_num};
    assign s_den[0] = i_den;
    assign s_q[0]   = '0;

    for (genvar k = 1; k < QB; k++) begin : g_link
        assign s_rem[k] = r_rem[k-1];
        assign s_den[k] = r_den[k-1];
        assign s_q[k]   = r_q[k-1];
    end

    // per stage: compare, subtract, shift
    always_comb begin
        logic [DW:0] diff;
        logic        bit_q;
        for (int k = 0; k < QB; k++) begin
            bit_q    = s_rem[k] >= {1'b0, s_den[k]};
            diff     = bit_q ? (s_rem[k] - {1'b0, s_den[k]}) : s_rem[k];
            n_rem[k] = {diff[DW-1:0], 1'b0};
            n_q[k]   = {s_q[k][QB-2:0], bit_q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QB; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_den[k] <= s_den[k];
            end
        end
    end

    assign o_quot = r_q[QB-1];

endmodule

FILE: rtl/pml_grading_coefficients_top.sv
// Top level: PML grading coefficients for one axis, streaming in and out.
//
//  channel | dir | handshake          | word
//  s_*     | in  | s_tvalid/s_tready  | tdata[11:0] coordinate
//  m_*     | out | m_tvalid/m_tready  | tdata: five Q3.16 coefficients; tuser: in_layer
//  apb     | in  | psel/penable       | 32-bit registers at 0x0, 0x4, 0x8, 0xC
//
// One word per cycle sustained while the output is not stalled; the path runs
// through the four front stages, the FRAC_BITS + 2 divider stages (one quotient bit each)
// and the output register.
// Reset is synchronous, active low; it clears valid bits and the config registers, not the payload.
// A stall at the output freezes the whole pipeline, so nothing is lost or repeated.
`timescale 1ns / 1ps

module pml_grading_coefficients_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB-style configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [11:0] coordinate
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // grade_inv, grade_ratio, half_profile, half_inv,
                                    // half_ratio (19 bits each), zero pad
    output logic [0:0]   m_tuser    // [0] in_layer
);
    import pgc_pkg::*;
    `include "assert_macros.svh"

    localparam int QB = FRAC_BITS + 2;
    localparam int WW = ((QB > OUT_BITS) ? QB : OUT_BITS) + 1;

    // saturate a signed magnitude into the output format
    function automatic logic [OUT_BITS-1:0] pack(input logic neg, input logic [QB-1:0] mag);
        logic [WW-1:0] ext;
        logic [WW-1:0] neg_v;
        logic [OUT_BITS-1:0] res;
        ext   = WW'(mag);
        neg_v = -ext;
        if (!neg) begin
            res = (ext > WW'({1'b0, {(OUT_BITS-1){1'b1}}})) ?
                  {1'b0, {(OUT_BITS-1){1'b1}}} : ext[OUT_BITS-1:0];
        end else begin
            res = (ext > (WW'(1) << (OUT_BITS-1))) ?
                  {1'b1, {(OUT_BITS-1){1'b0}}} : neg_v[OUT_BITS-1:0];
        end
        return res;
    endfunction

    localparam logic [OUT_BITS-1:0] C_ONE = pack(1'b0, QB'(1) << FRAC_BITS);

    t_cfg cfg;
    t_ops ops;
    logic adv, f_valid;

    assign pready   = 1'b1;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    pgc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    pgc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (s_tvalid),
        .i_coord (s_tdata[COORD_BITS-1:0]),
        .i_cfg   (cfg),
        .o_valid (f_valid),
        .o_ops   (ops)
    );

    // five dividers in parallel
    logic [QB-1:0] quot [NUM_COEF];

    for (genvar g = 0; g < NUM_COEF; g++) begin : g_div
        pgc_div #(.QB(QB)) u_div (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_num  (ops.num[g]),
            .i_den  (ops.den[g]),
            .o_quot (quot[g])
        );
    end

    // side bits matched to divider latency
    logic [QB-1:0] r_vld;
    logic [QB-1:0] r_hit, r_neg1, r_neg4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[QB-2:0], f_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hit  <= {r_hit[QB-2:0], ops.hit};
            r_neg1 <= {r_neg1[QB-2:0], ops.neg1};
            r_neg4 <= {r_neg4[QB-2:0], ops.neg4};
        end
    end

    // round half up and pack; every coefficient is 1.0 outside the layer
    logic [NUM_COEF-1:0][OUT_BITS-1:0] n_coef;
    logic [NUM_COEF-1:0][OUT_BITS-1:0] r_coef;
    logic                              r_out_valid, r_in_layer;

    always_comb begin
        logic [QB:0] rnd;
        for (int k = 0; k < NUM_COEF; k++) begin
            rnd = {1'b0, quot[k]} + (QB+1)'(1);
            if (!r_hit[QB-1]) begin
                n_coef[k] = C_ONE;
            end else if (k == 1) begin
                n_coef[k] = pack(r_neg1[QB-1], rnd[QB:1]);
            end else if (k == 4) begin
                n_coef[k] = pack(r_neg4[QB-1], rnd[QB:1]);
            end else begin
                n_coef[k] = pack(1'b0, rnd[QB:1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_vld[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_coef     <= n_coef;
            r_in_layer <= r_hit[QB-1];
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(96 - NUM_COEF*OUT_BITS){1'b0}}, r_coef};
    assign m_tuser  = r_in_layer;

    `ASSERT_IMPL(a_outside_one, i_clk, i_rst_n, m_tvalid && !m_tuser[0], (r_coef[0] == C_ONE) && (r_coef[2] == C_ONE) && (r_coef[4] == C_ONE), "outside layer not 1.0")
    `ASSERT_IMPL(a_inv_pos, i_clk, i_rst_n, m_tvalid && m_tuser[0], ($signed(r_coef[0]) > 0) && ($signed(r_coef[3]) > 0), "inverse coefficient not positive")
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, (m_tvalid && !m_tready) |=> (r_vld == $past(r_vld)), "pipeline moved during stall")

endmodule
